/* rtl/core/setr_pkg.sv */
package setr_pkg;

  localparam int unsigned EventDepth = 64;
  localparam int unsigned IdxW       = $clog2(EventDepth);
  localparam int unsigned SeqW       = 32;
  localparam int unsigned WordW      = 32;
  localparam int unsigned EntryW     = 5 * WordW;

  localparam logic [WordW-1:0] FaultMask = (WordW'(1) << 11) | (WordW'(1) << 10);
  localparam logic [WordW-1:0] StopFlag  = WordW'(1) << 31;
  localparam logic [SeqW-1:0]  DepthSeq  = SeqW'(EventDepth);

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_READ   = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_NONE   = 2'd3
  } setr_cmd_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [WordW-1:0] event_code;
    logic [WordW-1:0] arg0;
    logic [WordW-1:0] arg1;
    logic [WordW-1:0] arg2;
    logic [WordW-1:0] now_ms;
    logic [SeqW-1:0]  query_seq;
    logic [WordW-1:0] lcd_ctrl;
    logic [WordW-1:0] lcd_ctrl1;
    logic [WordW-1:0] lcd_debug;
  } setr_in_t;

  typedef struct packed {
    logic             found;
    logic [SeqW-1:0]  out_seq;
    logic [WordW-1:0] out_time;
    logic [WordW-1:0] out_code;
    logic [WordW-1:0] out_v0;
    logic [WordW-1:0] out_v1;
    logic [WordW-1:0] out_v2;
    logic [SeqW-1:0]  oldest_seq;
    logic [SeqW-1:0]  newest_next;
    logic             recorded;
  } setr_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } setr_ctl_t;

  function automatic logic [SeqW-1:0] oldest_of(logic [SeqW-1:0] seq);
    return (seq > DepthSeq) ? seq - DepthSeq : '0;
  endfunction

endpackage

/* rtl/core/setr_ram.sv */
module setr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/setr_ctrl.sv */
module setr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output setr_pkg::setr_ctl_t ctl_o
);
  import setr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;
  assign done_o = (state_q == ST_RESP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        // a new beat may be taken while the result is shown
        state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ctl_o.load = accept;
  assign ctl_o.exec = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/setr_datapath.sv */
module setr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  setr_pkg::setr_ctl_t ctl_i,
  input  setr_pkg::setr_in_t  item_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  output setr_pkg::setr_out_t result_o
);
  import setr_pkg::*;

  setr_in_t         item_q;
  logic [SeqW-1:0]  seq_q, seq_d;
  logic [WordW-1:0] last_fault_q, last_fault_d;
  logic [WordW-1:0] fault_code_q;

  logic             found_q, recorded_q;
  logic [SeqW-1:0]  out_seq_q, oldest_q, newest_q;

  logic [WordW-1:0] fault;
  logic             hit, do_write, fault_new;
  logic [SeqW-1:0]  out_seq_d;
  logic [EntryW-1:0] wdata, rdata;
  logic [IdxW-1:0]  addr;

  assign fault = (item_q.lcd_ctrl1 & FaultMask) | (item_q.lcd_ctrl[0] ? '0 : StopFlag);
  assign fault_new = (fault != '0) && (fault != last_fault_q);
  assign hit = (item_q.query_seq >= oldest_of(seq_q)) && (item_q.query_seq < seq_q);

  always_comb begin
    do_write     = 1'b0;
    wdata        = {item_q.now_ms, item_q.event_code, item_q.arg0, item_q.arg1, item_q.arg2};
    last_fault_d = last_fault_q;
    case (setr_cmd_e'(item_q.cmd))
      CMD_RECORD: begin
        do_write = 1'b1;
      end
      CMD_STATUS: begin
        do_write = fault_new;
        wdata    = {item_q.now_ms, fault_code_q, fault, item_q.lcd_ctrl, item_q.lcd_debug};
        if (fault_new) last_fault_d = fault;
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
  end

  assign seq_d = do_write ? seq_q + SeqW'(1) : seq_q;

  always_comb begin
    out_seq_d = '0;
    if (do_write) begin
      out_seq_d = seq_q;
    end else if ((setr_cmd_e'(item_q.cmd) == CMD_READ) && hit) begin
      out_seq_d = item_q.query_seq;
    end
  end

  // slot is the low sequence bits, ring depth is a power of two
  assign addr = do_write ? seq_q[IdxW-1:0] : item_q.query_seq[IdxW-1:0];

  setr_ram #(
    .Width (EntryW),
    .Depth (EventDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.exec && do_write),
    .re_i    (ctl_i.exec),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q <= item_i;
    end
    if (ctl_i.exec) begin
      out_seq_q <= out_seq_d;
      oldest_q  <= oldest_of(seq_d);
      newest_q  <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= '0;
      last_fault_q <= '0;
      fault_code_q <= '0;
      found_q      <= 1'b0;
      recorded_q   <= 1'b0;
    end else begin
      if (cfg_we_i) fault_code_q <= cfg_wdata_i;
      if (ctl_i.exec) begin
        seq_q        <= seq_d;
        last_fault_q <= last_fault_d;
        found_q      <= (setr_cmd_e'(item_q.cmd) == CMD_READ) && hit;
        recorded_q   <= do_write;
      end
    end
  end

  assign result_o.found       = found_q;
  assign result_o.out_seq     = out_seq_q;
  assign result_o.out_time    = found_q ? rdata[4*WordW +: WordW] : '0;
  assign result_o.out_code    = found_q ? rdata[3*WordW +: WordW] : '0;
  assign result_o.out_v0      = found_q ? rdata[2*WordW +: WordW] : '0;
  assign result_o.out_v1      = found_q ? rdata[1*WordW +: WordW] : '0;
  assign result_o.out_v2      = found_q ? rdata[0 +: WordW] : '0;
  assign result_o.oldest_seq  = oldest_q;
  assign result_o.newest_next = newest_q;
  assign result_o.recorded    = recorded_q;

endmodule

/* rtl/core/sequenced_event_trace_ring_top.sv */
// channel   signals                       direction  when a beat moves
// command   start, busy, item_i           in         start high, busy low
// result    done_o, result_o              out        done_o high, one cycle
// config    cfg_we_i, cfg_wdata_i         in         cfg_we_i high
//
// a command is shown on result_o after it is taken: in ST_EXEC the ring
// memory is written or read, in ST_RESP the result is shown. busy is high
// only in ST_EXEC, so a new command can be taken while a result is shown.
// reset clears the sequence counter, last fault and fault code; the ring
// itself is not cleared. results cannot be held off.
module sequenced_event_trace_ring_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  setr_pkg::setr_in_t  item_i,
  output logic                done_o,
  output setr_pkg::setr_out_t result_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);
  import setr_pkg::*;

  setr_ctl_t ctl;

  setr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctl_o  (ctl)
  );

  setr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result_o)
  );

endmodule

/* rtl/core/setr_checker.sv */
module setr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input setr_pkg::setr_out_t result_o
);
  import setr_pkg::*;

  // every taken beat raises busy and then yields a result
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy ##1 done_o)
    else $error("taken command gave no result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |->
      (result_o.out_time == '0) && (result_o.out_code == '0) && (result_o.out_v0 == '0) &&
      (result_o.out_v1 == '0) && (result_o.out_v2 == '0))
    else $error("entry fields not zero without a hit");

  a_record_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.recorded) |->
      (result_o.newest_next == result_o.out_seq + SeqW'(1)) && !result_o.found)
    else $error("record does not advance sequence");

endmodule

bind sequenced_event_trace_ring_top setr_checker u_setr_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  import setr_pkg::*;

  localparam logic [WordW-1:0] FaultBits = 32'h0000_0C00;
  localparam logic [WordW-1:0] StopBit   = 32'h8000_0000;
  localparam logic [SeqW-1:0]  RingSize  = SeqW'(EventDepth);

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      start       = 1'b0;
  logic      busy;
  setr_in_t  item_i      = '0;
  logic      done_o;
  setr_out_t result_o;
  logic      cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  sequenced_event_trace_ring_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // trace ring shadow
  logic [SeqW-1:0]  next_seq        = '0;
  logic [WordW-1:0] last_fault_word = '0;
  logic [WordW-1:0] fault_code      = '0;
  logic [WordW-1:0] ring_time [EventDepth];
  logic [WordW-1:0] ring_code [EventDepth];
  logic [WordW-1:0] ring_v0   [EventDepth];
  logic [WordW-1:0] ring_v1   [EventDepth];
  logic [WordW-1:0] ring_v2   [EventDepth];

  setr_out_t   awaited_results[$];
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  bit          no_gaps     = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [SeqW-1:0] window_floor();
    return (next_seq > RingSize) ? next_seq - RingSize : '0;
  endfunction

  function automatic logic [SeqW-1:0] ring_append(logic [WordW-1:0] t, logic [WordW-1:0] c,
                                                  logic [WordW-1:0] a, logic [WordW-1:0] b,
                                                  logic [WordW-1:0] e);
    int unsigned slot;
    logic [SeqW-1:0] seq;
    seq  = next_seq;
    slot = seq % EventDepth;
    ring_time[slot] = t;
    ring_code[slot] = c;
    ring_v0[slot]   = a;
    ring_v1[slot]   = b;
    ring_v2[slot]   = e;
    next_seq = seq + 1'b1;
    return seq;
  endfunction

  function automatic setr_out_t trace_predict(setr_in_t c);
    setr_out_t r;
    logic [WordW-1:0] fault;
    int unsigned slot;
    r = '0;
    case (c.cmd)
      CMD_RECORD: begin
        r.out_seq  = ring_append(c.now_ms, c.event_code, c.arg0, c.arg1, c.arg2);
        r.recorded = 1'b1;
      end
      CMD_READ: begin
        if (c.query_seq >= window_floor() && c.query_seq < next_seq) begin
          slot       = c.query_seq % EventDepth;
          r.found    = 1'b1;
          r.out_seq  = c.query_seq;
          r.out_time = ring_time[slot];
          r.out_code = ring_code[slot];
          r.out_v0   = ring_v0[slot];
          r.out_v1   = ring_v1[slot];
          r.out_v2   = ring_v2[slot];
        end
      end
      CMD_STATUS: begin
        fault = c.lcd_ctrl1 & FaultBits;
        if (!c.lcd_ctrl[0]) fault = fault | StopBit;
        if (fault != '0 && fault != last_fault_word) begin
          last_fault_word = fault;
          r.out_seq  = ring_append(c.now_ms, fault_code, fault, c.lcd_ctrl, c.lcd_debug);
          r.recorded = 1'b1;
        end
      end
      default: ;
    endcase
    r.oldest_seq  = window_floor();
    r.newest_next = next_seq;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    setr_out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no command outstanding");
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("found", 32'(want.found), 32'(result_o.found));
        check_field("out_seq", want.out_seq, result_o.out_seq);
        check_field("out_time", want.out_time, result_o.out_time);
        check_field("out_code", want.out_code, result_o.out_code);
        check_field("out_v0", want.out_v0, result_o.out_v0);
        check_field("out_v1", want.out_v1, result_o.out_v1);
        check_field("out_v2", want.out_v2, result_o.out_v2);
        check_field("oldest_seq", want.oldest_seq, result_o.oldest_seq);
        check_field("newest_next", want.newest_next, result_o.newest_next);
        check_field("recorded", 32'(want.recorded), 32'(result_o.recorded));
      end
    end
  end

  // start stays high from one beat to the next unless the sender pauses
  task automatic send_command(input setr_in_t c);
    @(negedge clk_i);
    start  = 1'b1;
    item_i = c;
    do @(posedge clk_i); while (busy !== 1'b0);
    awaited_results.push_back(trace_predict(c));
  endtask

  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk_i);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_fault_code(input logic [31:0] value);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    fault_code = value;
  endtask

  function automatic logic [31:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom();
  endfunction

  // unused fields carry noise so that the block has to ignore them
  function automatic setr_in_t noisy_command(setr_cmd_e cmd);
    setr_in_t c;
    c.cmd        = cmd;
    c.event_code = $urandom();
    c.arg0       = $urandom();
    c.arg1       = $urandom();
    c.arg2       = $urandom();
    c.now_ms     = $urandom();
    c.query_seq  = $urandom();
    c.lcd_ctrl   = $urandom();
    c.lcd_ctrl1  = $urandom();
    c.lcd_debug  = $urandom();
    return c;
  endfunction

  function automatic setr_in_t read_command(logic [SeqW-1:0] q);
    setr_in_t c;
    c = noisy_command(CMD_READ);
    c.query_seq = q;
    return c;
  endfunction

  function automatic setr_in_t status_command(logic [31:0] ctrl, logic [31:0] ctrl1);
    setr_in_t c;
    c = noisy_command(CMD_STATUS);
    c.lcd_ctrl  = ctrl;
    c.lcd_ctrl1 = ctrl1;
    return c;
  endfunction

  function automatic setr_in_t random_command();
    setr_in_t c;
    int unsigned pick;
    logic [SeqW-1:0] lo;
    pick = $urandom_range(0, 99);
    lo   = window_floor();
    if (pick < 40) begin
      c = noisy_command(CMD_RECORD);
      c.event_code = rand_word();
      c.arg0       = rand_word();
      c.arg1       = rand_word();
      c.arg2       = rand_word();
      c.now_ms     = rand_word();
    end else if (pick < 72) begin
      c = noisy_command(CMD_READ);
      pick = $urandom_range(0, 99);
      if (next_seq == '0 || pick < 10) c.query_seq = rand_word();
      else if (pick < 60) c.query_seq = lo + SeqW'($urandom_range(0, next_seq - lo - 1));
      else if (pick < 70) c.query_seq = lo;
      else if (pick < 80) c.query_seq = next_seq - 1'b1;
      else if (pick < 90) c.query_seq = next_seq;
      else c.query_seq = (lo != '0) ? lo - 1'b1 : next_seq + 1'b1;
    end else if (pick < 92) begin
      c = noisy_command(CMD_STATUS);
      c.now_ms = rand_word();
    end else begin
      c = noisy_command(CMD_NONE);
    end
    return c;
  endfunction

  task automatic test_empty_ring();
    send_command(read_command('0));
    send_command(read_command('1));
    // run enabled and no fault bits: fault word stays zero
    send_command(status_command(32'h0000_0001, 32'hFFFF_F3FF));
  endtask

  task automatic test_record_extremes();
    setr_in_t c;
    c = '0;
    c.cmd = CMD_RECORD;
    send_command(c);
    c = '1;
    c.cmd = CMD_RECORD;
    send_command(c);
    send_command(read_command(32'd0));
    send_command(read_command(32'd1));
    send_command(read_command(next_seq));
    send_command(read_command(32'h8000_0000));
  endtask

  task automatic test_fault_events();
    write_fault_code('1);
    send_command(status_command(32'h0000_0000, 32'h0000_0000));
    // same fault word again is not logged twice
    send_command(status_command(32'hFFFF_FFFE, 32'hFFFF_F3FF));
    send_command(status_command(32'h0000_0001, 32'h0000_0000));
    send_command(status_command(32'h0000_0001, 32'h0000_0400));
    send_command(status_command(32'hFFFF_FFFF, 32'h0000_0800));
    send_command(status_command(32'hFFFF_FFFE, 32'hFFFF_FFFF));
    send_command(status_command(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_command(read_command(next_seq - 1'b1));
  endtask

  task automatic test_unused_command();
    setr_in_t c;
    send_command(noisy_command(CMD_NONE));
    c = '1;
    send_command(c);
  endtask

  task automatic test_random_traffic(input int unsigned per_phase);
    logic [31:0] codes [4];
    codes[0] = '0;
    codes[1] = $urandom();
    codes[2] = '1;
    codes[3] = $urandom();
    for (int p = 0; p < 4; p++) begin
      write_fault_code(codes[p]);
      no_gaps    = (p == 2);
      burst_left = 0;
      for (int unsigned n = 0; n < per_phase; n++) begin
        if (!no_gaps) begin
          if (burst_left == 0) begin
            pause_sender($urandom_range(1, 7));
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
        end
        // now and then hold off until the pipeline is empty
        if ($urandom_range(0, 299) == 0) drain_results();
        send_command(random_command());
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    write_fault_code('0);
    test_empty_ring();
    test_record_extremes();
    test_fault_events();
    test_unused_command();
    test_random_traffic(500);
    drain_results();
    repeat (8) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
